// ===== rtl/nmea_pkg.sv =====
// nmea_pkg: types, codes, constants and decode tables of the sentence parser
// depends on nothing; imported by every module of the parser
package nmea_pkg;

  localparam int FIELD_CHARS_MAX_DEF = 31;
  localparam int FRACTION_DIGITS_DEF = 5;
  localparam int OPQ_DEPTH           = 4;
  localparam int STORE_DEPTH         = 11;
  localparam int RECORDS_GGA         = 9;
  localparam int RECORDS_RMC         = 11;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FORMAT   = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  localparam logic [23:0] TYPE_GGA   = 24'h474741;
  localparam logic [23:0] TYPE_RMC   = 24'h524D43;
  localparam logic [31:0] YEAR_BASE  = 32'd2000;
  localparam logic [31:0] SAT_MAG    = 32'h8000_0000;
  localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;
  localparam logic [3:0]  DATE_YEAR_SLOT = 4'd10;

  typedef struct packed {
    logic [7:0] sentence_byte;
    logic       end_of_sentence;
  } sentence_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               sentence_kind;
    logic [3:0]         field_id;
    logic signed [31:0] field_value;
    logic               last;
  } record_t;

  typedef enum logic [1:0] {KIND_GGA, KIND_RMC, KIND_NONE} kind_t;

  typedef enum logic [3:0] {
    R_NONE, R_TIME, R_COORD, R_DIR, R_INT, R_CENTI, R_DECI, R_SPEED, R_VALID, R_DATE
  } role_t;

  typedef enum logic [1:0] {PH_WAIT, PH_BODY, PH_TAIL, PH_REJECT} phase_t;

  typedef enum logic [1:0] {NUM_START, NUM_WHOLE, NUM_FRAC, NUM_STOP} num_phase_t;

  typedef enum logic [3:0] {
    B_IDLE, B_EXEC, B_SATCHK, B_MULP, B_MULN, B_DIV, B_POST, B_CRDM, B_CRDS, B_NEXT, B_EMIT
  } back_state_t;

  // one classified byte, handed from the front to the back
  typedef struct packed {
    logic       feed;
    logic       close;
    logic       finish;
    logic [7:0] chr;
    role_t      role;
    logic [3:0] slot;
    logic [2:0] pos;       // char position in field, saturated at 7
    logic       nonempty;
    logic [1:0] status;
    logic       kind;
  } op_t;

  function automatic kind_t kind_of(input logic [23:0] code);
    if (code == TYPE_GGA) return KIND_GGA;
    if (code == TYPE_RMC) return KIND_RMC;
    return KIND_NONE;
  endfunction

  function automatic role_t field_role(input kind_t kind, input logic [4:0] fnum);
    role_t r;
    r = R_NONE;
    if (kind == KIND_GGA) begin
      unique case (fnum)
        5'd1:           r = R_TIME;
        5'd2, 5'd4:     r = R_COORD;
        5'd3, 5'd5:     r = R_DIR;
        5'd6, 5'd7:     r = R_INT;
        5'd8:           r = R_CENTI;
        5'd9:           r = R_DECI;
        default:        r = R_NONE;
      endcase
    end else if (kind == KIND_RMC) begin
      unique case (fnum)
        5'd1:           r = R_TIME;
        5'd2:           r = R_VALID;
        5'd3, 5'd5:     r = R_COORD;
        5'd4, 5'd6:     r = R_DIR;
        5'd7:           r = R_SPEED;
        5'd8:           r = R_CENTI;
        5'd9:           r = R_DATE;
        default:        r = R_NONE;
      endcase
    end
    return r;
  endfunction

  // store slot, time/date base slot, or direction index
  function automatic logic [3:0] field_slot(input kind_t kind, input logic [4:0] fnum);
    logic [3:0] s;
    s = 4'd0;
    if (kind == KIND_GGA) begin
      unique case (fnum)
        5'd2:    s = 4'd3;
        5'd4:    s = 4'd4;
        5'd5:    s = 4'd1;
        5'd6:    s = 4'd5;
        5'd7:    s = 4'd6;
        5'd8:    s = 4'd7;
        5'd9:    s = 4'd8;
        default: s = 4'd0;
      endcase
    end else if (kind == KIND_RMC) begin
      unique case (fnum)
        5'd2:    s = 4'd5;
        5'd3:    s = 4'd3;
        5'd5:    s = 4'd4;
        5'd6:    s = 4'd1;
        5'd7:    s = 4'd6;
        5'd8:    s = 4'd7;
        5'd9:    s = 4'd8;
        default: s = 4'd0;
      endcase
    end
    return s;
  endfunction

  function automatic logic [3:0] record_id(input logic rmc, input logic [3:0] idx);
    if (rmc && idx >= 4'd5) return idx + 4'd4;
    return idx;
  endfunction

  function automatic logic [23:0] pow10(input logic [2:0] n);
    logic [23:0] p;
    unique case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return 5'(b - CH_ZERO);
    if (b >= CH_A && b <= CH_F)       return 5'(b - CH_A + 8'd10);
    if (b >= CH_LA && b <= CH_LF_HEX) return 5'(b - CH_LA + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic [31:0] signed_clamp(input logic [63:0] mag, input logic neg);
    logic [31:0] m;
    m = (mag > 64'(SAT_MAG)) ? SAT_MAG : mag[31:0];
    if (neg) return 32'd0 - m;
    return (m > POS_MAX) ? POS_MAX : m;
  endfunction

  function automatic logic [10:0] role_num(input role_t r);
    if (r == R_CENTI) return 11'd100;
    if (r == R_DECI)  return 11'd10;
    return 11'd1852;
  endfunction

  function automatic logic [3:0] role_den(input role_t r);
    if (r == R_SPEED) return 4'd10;
    return 4'd1;
  endfunction

endpackage

// ===== rtl/nmea_front.sv =====
// nmea_front: byte classifier; tracks framing, type, fields and checksum
// depends on nmea_pkg; feeds nmea_opq with at most one op per accepted byte
module nmea_front import nmea_pkg::*; #(
  parameter int FIELD_CHARS_MAX = FIELD_CHARS_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  sentence_t sentence,
  output op_t       op,
  output logic      op_push
);

  localparam int CNT_W = $clog2(FIELD_CHARS_MAX + 1);

  phase_t           phase, phase_next;
  logic [7:0]       pos, pos_next;
  logic [4:0]       fnum, fnum_next;
  logic [7:0]       xsum, xsum_next;
  logic [7:0]       dsum, dsum_next;
  logic [1:0]       hexcnt, hexcnt_next;
  logic [23:0]      type_code, type_code_next;
  logic [CNT_W-1:0] cc, cc_next;
  logic             field_open, field_open_next;
  logic [1:0]       tail_cnt, tail_cnt_next;
  logic             hex_done, hex_done_next;
  logic             string_ended, string_ended_next;

  logic [7:0] b;
  logic [4:0] hex_v;
  kind_t      kind_w;
  role_t      role_w;
  logic [3:0] slot_w;
  logic       fmt_bad, sum_bad;

  always_comb begin
    phase_next        = phase;
    pos_next          = pos;
    fnum_next         = fnum;
    xsum_next         = xsum;
    dsum_next         = dsum;
    hexcnt_next       = hexcnt;
    type_code_next    = type_code;
    cc_next           = cc;
    field_open_next   = field_open;
    tail_cnt_next     = tail_cnt;
    hex_done_next     = hex_done;
    string_ended_next = string_ended;
    op                = '0;
    b                 = sentence.sentence_byte;
    hex_v             = hex_nibble(b);
    kind_w            = KIND_NONE;
    role_w            = R_NONE;
    slot_w            = 4'd0;
    fmt_bad           = 1'b0;
    sum_bad           = 1'b0;
    if (accept) begin
      if (!(string_ended || phase == PH_REJECT)) begin
        if (phase == PH_WAIT) begin
          if (b == CH_DOLLAR) begin
            phase_next = PH_BODY;
            pos_next   = 8'd1;
          end else begin
            phase_next = PH_REJECT;
          end
        end else if (b == CH_NUL) begin
          string_ended_next = 1'b1;
        end else begin
          if (pos != 8'd255) pos_next = pos + 8'd1;
          if (phase == PH_BODY) begin
            if (pos >= 8'd3 && pos <= 8'd5) type_code_next = {type_code[15:0], b};
            kind_w      = kind_of(type_code_next);
            role_w      = field_role(kind_w, fnum);
            slot_w      = field_slot(kind_w, fnum);
            op.role     = role_w;
            op.slot     = slot_w;
            op.chr      = b;
            op.nonempty = (cc != '0);
            op.pos      = (cc > CNT_W'(7)) ? 3'd7 : cc[2:0];
            if (b == CH_STAR) begin
              op.close        = 1'b1;
              cc_next         = '0;
              field_open_next = 1'b0;
              phase_next      = PH_TAIL;
            end else begin
              xsum_next = xsum ^ b;
              if (b == CH_COMMA) begin
                op.close        = 1'b1;
                cc_next         = '0;
                field_open_next = 1'b1;
                if (fnum != 5'd31) fnum_next = fnum + 5'd1;
              end else if (field_open) begin
                if (b == CH_CR || b == CH_LF) begin
                  field_open_next = 1'b0;
                end else if (cc < CNT_W'(FIELD_CHARS_MAX)) begin
                  op.feed = (role_w != R_NONE);
                  cc_next = cc + 1'b1;
                end
              end
            end
          end else begin
            // checksum digits after the star
            if (tail_cnt != 2'd2) tail_cnt_next = tail_cnt + 2'd1;
            if (!hex_done) begin
              if (!hex_v[4] && hexcnt != 2'd2) begin
                dsum_next   = {dsum[3:0], hex_v[3:0]};
                hexcnt_next = hexcnt + 2'd1;
                if (hexcnt == 2'd1) hex_done_next = 1'b1;
              end else begin
                hex_done_next = 1'b1;
              end
            end
          end
        end
      end
      if (sentence.end_of_sentence) begin
        fmt_bad = (phase_next == PH_REJECT) || (phase_next == PH_WAIT) ||
                  (pos_next < 8'd7) || (kind_of(type_code_next) == KIND_NONE);
        sum_bad = (phase_next != PH_TAIL) || (tail_cnt_next != 2'd2) ||
                  (hexcnt_next == 2'd0) || (xsum_next != dsum_next);
        op.finish = 1'b1;
        op.status = fmt_bad ? STATUS_FORMAT : (sum_bad ? STATUS_CHECKSUM : STATUS_OK);
        op.kind   = (kind_of(type_code_next) == KIND_RMC);
      end
    end
    op_push = accept && (op.feed || op.close || op.finish);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && sentence.end_of_sentence)) begin
      phase        <= PH_WAIT;
      pos          <= '0;
      fnum         <= '0;
      xsum         <= '0;
      dsum         <= '0;
      hexcnt       <= '0;
      type_code    <= '0;
      cc           <= '0;
      field_open   <= 1'b1;
      tail_cnt     <= '0;
      hex_done     <= 1'b0;
      string_ended <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      pos          <= pos_next;
      fnum         <= fnum_next;
      xsum         <= xsum_next;
      dsum         <= dsum_next;
      hexcnt       <= hexcnt_next;
      type_code    <= type_code_next;
      cc           <= cc_next;
      field_open   <= field_open_next;
      tail_cnt     <= tail_cnt_next;
      hex_done     <= hex_done_next;
      string_ended <= string_ended_next;
    end
  end

endmodule

// ===== rtl/nmea_opq.sv =====
// nmea_opq: short op queue between the byte classifier and the field engine
// depends on nmea_pkg
module nmea_opq import nmea_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  wdata,
  output logic full,
  input  logic pop,
  output op_t  rdata,
  output logic empty
);

  localparam int PTR_W = $clog2(OPQ_DEPTH);

  op_t            slots [OPQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign full    = (count == (PTR_W + 1)'(OPQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end
  end

endmodule

// ===== rtl/nmea_back.sv =====
// nmea_back: field engine; number decode, scaling divider, field store, record output
// depends on nmea_pkg; takes ops from nmea_opq
module nmea_back import nmea_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  op_t     op,
  input  logic    op_empty,
  output logic    op_pop,
  input  logic    pop,
  output logic    empty,
  output record_t result
);

  localparam int FRAC_W = $clog2(10 ** FRACTION_DIGITS);
  // floor(x / 100) == (x * RECIP_100) >> 37 for any 32-bit x
  localparam logic [63:0] RECIP_100 = 64'd1374389535;

  back_state_t state, state_next;
  op_t         op_r;

  num_phase_t        num_phase;
  logic [31:0]       whole;
  logic [FRAC_W-1:0] frac;
  logic [2:0]        fd;
  logic              minus;

  logic [31:0] store [STORE_DEPTH];
  logic [1:0]  sw, cminus;

  logic [55:0] acc;
  logic [63:0] quo;
  logic [31:0] rem, divisor;
  logic [5:0]  div_cnt;
  logic        second;
  logic [24:0] deg;
  logic [29:0] mval;

  logic [3:0] emit_idx;
  logic       out_valid;

  // combinational helpers
  logic        is_digit;
  logic [3:0]  dval;
  logic [34:0] w10;
  logic [FRAC_W+3:0] f10;
  logic [23:0] pw;
  logic [3:0]  rd_idx;
  logic [31:0] store_rd;
  logic [43:0] wnum;
  logic        sat_hit, is_scaled;
  logic [32:0] div_shift;
  logic        div_ge;
  logic [63:0] coord_sum;
  logic [3:0]  last_idx;
  logic        emit_final, out_load;
  logic [1:0]  neg_bits;
  record_t     rec;

  assign empty = !out_valid;

  always_comb begin
    is_digit  = (op_r.chr >= CH_ZERO) && (op_r.chr <= CH_NINE);
    dval      = 4'(op_r.chr - CH_ZERO);
    w10       = 35'(whole) * 35'd10 + 35'(dval);
    f10       = (FRAC_W + 4)'(frac) * (FRAC_W + 4)'(10) + (FRAC_W + 4)'(dval);
    pw        = pow10(fd);
    wnum      = 44'(whole) * 44'(role_num(op_r.role));
    sat_hit   = wnum >= (44'(role_den(op_r.role)) << 31);
    is_scaled = (op_r.role == R_CENTI) || (op_r.role == R_DECI) || (op_r.role == R_SPEED);
    div_shift = {rem, quo[63]};
    div_ge    = div_shift >= {1'b0, divisor};
    coord_sum = 64'(deg) * 64'd10000000 + quo;
    last_idx  = op_r.kind ? 4'(RECORDS_RMC - 1) : 4'(RECORDS_GGA - 1);
    if (state == B_EMIT)  rd_idx = emit_idx;
    else if (op_r.close)  rd_idx = DATE_YEAR_SLOT;
    else                  rd_idx = op_r.slot + {2'b00, op_r.pos[2:1]};
    store_rd = store[rd_idx];
    neg_bits = cminus ^ sw;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (!op_empty) state_next = B_EXEC;
      B_EXEC: begin
        if (op_r.feed) state_next = op_r.finish ? B_EMIT : B_IDLE;
        else if (op_r.close) begin
          if (op_r.nonempty && is_scaled)              state_next = B_SATCHK;
          else if (op_r.nonempty && op_r.role == R_COORD) state_next = B_POST;
          else                                         state_next = B_NEXT;
        end else state_next = B_EMIT;
      end
      B_SATCHK: state_next = sat_hit ? B_NEXT : B_MULP;
      B_MULP:   state_next = B_MULN;
      B_MULN:   state_next = B_DIV;
      B_DIV:    if (div_cnt == 6'd63) state_next = B_POST;
      B_POST:   state_next = (op_r.role == R_COORD && !second) ? B_CRDM : B_NEXT;
      B_CRDM:   state_next = B_CRDS;
      B_CRDS:   state_next = B_DIV;
      B_NEXT:   state_next = op_r.finish ? B_EMIT : B_IDLE;
      B_EMIT:   if (out_load && emit_final) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // strobes and the outgoing record
  always_comb begin
    op_pop     = (state == B_IDLE) && !op_empty;
    out_load   = (state == B_EMIT) && (!out_valid || pop);
    emit_final = (op_r.status != STATUS_OK) || (emit_idx == last_idx);
    rec        = '0;
    rec.last   = 1'b1;
    if (op_r.status != STATUS_OK) begin
      rec.status = op_r.status;
    end else begin
      rec.status        = STATUS_OK;
      rec.sentence_kind = op_r.kind;
      rec.field_id      = record_id(op_r.kind, emit_idx);
      rec.last          = (emit_idx == last_idx);
      if (emit_idx == 4'd3 || emit_idx == 4'd4)
        rec.field_value = signed_clamp(64'(store_rd), neg_bits[emit_idx == 4'd4]);
      else
        rec.field_value = store_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (out_load) result <= rec;
    if (op_pop)   op_r   <= op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) store[i] <= '0;
      sw        <= '0;
      cminus    <= '0;
      num_phase <= NUM_START;
      whole     <= '0;
      frac      <= '0;
      fd        <= '0;
      minus     <= 1'b0;
      emit_idx  <= '0;
      second    <= 1'b0;
    end else begin
      if (out_load)             out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        B_IDLE: emit_idx <= '0;
        B_EXEC: begin
          second <= 1'b0;
          if (op_r.feed) begin
            case (op_r.role) inside
              R_TIME, R_DATE: begin
                if (num_phase == NUM_START) begin
                  if (is_digit && op_r.pos < 3'd6)
                    store[rd_idx] <= store_rd * 32'd10 + 32'(dval);
                  else
                    num_phase <= NUM_STOP;
                end
              end
              R_VALID: begin
                if (op_r.pos == 3'd0) store[op_r.slot] <= 32'(op_r.chr == CH_A);
              end
              R_DIR: begin
                if (op_r.pos == 3'd0 && (op_r.chr == CH_S || op_r.chr == CH_W))
                  sw[op_r.slot[0]] <= 1'b1;
              end
              R_COORD, R_INT, R_CENTI, R_DECI, R_SPEED: begin
                if (num_phase == NUM_START &&
                    (op_r.chr == CH_PLUS || op_r.chr == CH_MINUS)) begin
                  minus     <= (op_r.chr == CH_MINUS);
                  num_phase <= NUM_WHOLE;
                end else if (num_phase == NUM_START || num_phase == NUM_WHOLE) begin
                  if (is_digit) begin
                    whole     <= (w10 > 35'(SAT_MAG)) ? SAT_MAG : w10[31:0];
                    num_phase <= NUM_WHOLE;
                  end else if (op_r.chr == CH_DOT) begin
                    num_phase <= NUM_FRAC;
                  end else begin
                    num_phase <= NUM_STOP;
                  end
                end else if (num_phase == NUM_FRAC) begin
                  if (!is_digit) num_phase <= NUM_STOP;
                  else if (fd < 3'(FRACTION_DIGITS)) begin
                    frac <= f10[FRAC_W-1:0];
                    fd   <= fd + 3'd1;
                  end
                end
              end
              default: ;
            endcase
          end else if (op_r.close && op_r.nonempty) begin
            case (op_r.role)
              R_COORD: begin
                // degrees and minutes split: whole / 100 by reciprocal multiply
                quo <= 64'(whole) * RECIP_100;
              end
              R_INT:  store[op_r.slot] <= signed_clamp(64'(whole), minus);
              R_DATE: store[DATE_YEAR_SLOT] <= store_rd + YEAR_BASE;
              default: ;
            endcase
          end
        end
        B_SATCHK: if (sat_hit) store[op_r.slot] <= signed_clamp(64'(SAT_MAG), minus);
        B_MULP:   acc <= 56'(whole) * 56'(pw) + 56'(frac);
        B_MULN: begin
          quo     <= 64'(acc) * 64'(role_num(op_r.role));
          divisor <= 32'(role_den(op_r.role)) * 32'(pw);
          rem     <= '0;
          div_cnt <= '0;
        end
        B_DIV: begin
          // restoring divide, one quotient bit a cycle
          rem     <= div_ge ? 32'(div_shift - {1'b0, divisor}) : div_shift[31:0];
          quo     <= {quo[62:0], div_ge};
          div_cnt <= div_cnt + 6'd1;
        end
        B_POST: begin
          if (op_r.role == R_COORD && !second) begin
            // degrees and the whole minutes left over
            deg    <= quo[61:37];
            rem    <= whole - 32'(quo[61:37]) * 32'd100;
            second <= 1'b1;
          end else if (op_r.role == R_COORD) begin
            store[op_r.slot] <= (coord_sum > 64'(SAT_MAG)) ? SAT_MAG : coord_sum[31:0];
            if (minus) cminus[op_r.slot == 4'd4] <= 1'b1;
          end else begin
            store[op_r.slot] <= signed_clamp(quo, minus);
          end
        end
        B_CRDM: mval <= 30'(rem[6:0]) * 30'(pw) + 30'(frac);
        B_CRDS: begin
          // minutes to degrees: m * 1e7 / (60 * 10^fd)
          quo     <= 64'(mval) * 64'd10000000;
          divisor <= 32'd60 * 32'(pw);
          rem     <= '0;
          div_cnt <= '0;
        end
        B_NEXT: begin
          num_phase <= NUM_START;
          whole     <= '0;
          frac      <= '0;
          fd        <= '0;
          minus     <= 1'b0;
        end
        B_EMIT: begin
          if (out_load && emit_final) begin
            for (int i = 0; i < STORE_DEPTH; i++) store[i] <= '0;
            sw        <= '0;
            cminus    <= '0;
            num_phase <= NUM_START;
            whole     <= '0;
            frac      <= '0;
            fd        <= '0;
            minus     <= 1'b0;
          end else if (out_load) begin
            emit_idx <= emit_idx + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/nmea_gga_rmc_sentence_parser.sv =====
// nmea_gga_rmc_sentence_parser: top level of the GGA / RMC sentence parser
// depends on nmea_pkg, nmea_front, nmea_opq and nmea_back
//
//   port      dir   payload      handshake
//   sentence  in    sentence_t   push / full   (word taken when push & !full)
//   result    out   record_t     empty / pop   (word taken when pop & !empty)
//
// the front takes one byte word per cycle while the op queue has room
// each feed op passes the field engine through B_IDLE and B_EXEC, a plain field close also through B_NEXT
// closing a coordinate field, or a scaled field that does not saturate, runs the 64-step divider
// the final byte releases 1, 9 or 11 result words, one a cycle while popped
// rst is synchronous; it clears framing state, the queue and the field store
// a full result register stalls only the field engine; the op queue keeps
//   the front taking bytes until it fills
module nmea_gga_rmc_sentence_parser import nmea_pkg::*; #(
  parameter int FIELD_CHARS_MAX = FIELD_CHARS_MAX_DEF,
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  sentence_t sentence,
  output logic      empty,
  input  logic      pop,
  output record_t   result
);

  // classified ops from front to back
  op_t  q_wdata, q_rdata;
  logic q_push, q_pop, q_empty;
  logic accept;

  assign accept = push && !full;

  // framing, type, field numbering and checksum
  nmea_front #(
    .FIELD_CHARS_MAX(FIELD_CHARS_MAX)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .sentence(sentence),
    .op      (q_wdata),
    .op_push (q_push)
  );

  // decoupling queue; its full flag is the input back-pressure
  nmea_opq u_opq (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  // number decode, scaling, field store and result register
  nmea_back #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .op      (q_rdata),
    .op_empty(q_empty),
    .op_pop  (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // an op is never produced while the queue has no room
  assert property (@(posedge clk) disable iff (rst) q_push |-> !full)
    else $error("op queue overflow");

  // error words stand alone and carry nothing else
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != STATUS_OK) |->
      (result.last && result.field_id == 4'd0 && result.field_value == 32'sd0 &&
       !result.sentence_kind))
    else $error("malformed error word");

  // field ids and status codes stay within the defined set
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.field_id != 4'd15 && result.status != 2'd3))
    else $error("field id or status out of range");

endmodule
